[hw/rtl/metric_history_ring_macros.svh]
// Assertion macros shared by the metric history ring RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef METRIC_HISTORY_RING_MACROS_SVH
`define METRIC_HISTORY_RING_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define MHR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define MHR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/mhr_pkg.sv]
// Package for the metric history ring: sizes, command codes, point and control types.
// No dependencies; used by the interfaces, the top, the controller and the datapath.
package mhr_pkg;

    localparam int CAPACITY   = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    localparam int CMD_W      = 2;
    localparam int TIME_W     = 48;
    localparam int RAW_W      = 16;
    localparam int PCT_W      = 15;
    localparam int LOAD_W     = 16;
    localparam int CORE_W     = 8;
    localparam int WIN_W      = 16;

    localparam int LOAD_SCALE = 100;
    localparam int MS_PER_S   = 1000;
    localparam int DIV_W      = LOAD_W + 7;
    localparam int DIV_CNT_W  = $clog2(DIV_W);
    localparam int SPAN_W     = WIN_W + 10;

    localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(25600);

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 2'd0,
        CMD_CLEAR  = 2'd1,
        CMD_QUERY  = 2'd2
    } t_cmd;

    typedef struct packed {
        logic [CMD_W-1:0]         command;
        logic [TIME_W-1:0]        sample_time;
        logic                     sample_time_valid;
        logic [TIME_W-1:0]        now_time;
        logic                     cpu_ready;
        logic signed [RAW_W-1:0]  cpu_in;
        logic signed [RAW_W-1:0]  memory_in;
        logic signed [RAW_W-1:0]  disk_in;
        logic [LOAD_W-1:0]        load_avg;
        logic [CORE_W-1:0]        core_count;
        logic [WIN_W-1:0]         window_secs;
    } t_in_item;

    typedef struct packed {
        logic [TIME_W-1:0] stamp;
        logic              cpu_valid;
        logic [PCT_W-1:0]  cpu;
        logic [PCT_W-1:0]  memory;
        logic [PCT_W-1:0]  load;
        logic [PCT_W-1:0]  disk;
    } t_point;

    typedef struct packed {
        logic accept;
        logic clear;
        logic div_step;
        logic write;
        logic rd_newest;
        logic set_cutoff;
        logic rd_walk;
        logic walk_next;
        logic emit;
    } t_ctl_cmd;

    typedef struct packed {
        logic [CMD_W-1:0] in_cmd;
        logic             empty;
        logic             div_done;
        logic             hit;
        logic             walk_end;
        logic             out_free;
    } t_ctl_sts;

    function automatic logic [PCT_W-1:0] clamp_pct(input logic signed [RAW_W-1:0] v);
        logic [PCT_W-1:0] res;
        if (v[RAW_W-1]) begin
            res = '0;
        end else if (v[RAW_W-2:0] > PCT_FULL) begin
            res = PCT_FULL;
        end else begin
            res = v[RAW_W-2:0];
        end
        return res;
    endfunction

    function automatic logic [IDX_W-1:0] idx_wrap(input logic [IDX_W:0] s);
        logic [IDX_W-1:0] res;
        if (s >= (IDX_W+1)'(CAPACITY)) begin
            res = IDX_W'(s - (IDX_W+1)'(CAPACITY));
        end else begin
            res = s[IDX_W-1:0];
        end
        return res;
    endfunction

endpackage

[hw/rtl/mhr_in_if.sv]
// Input channel of the metric history ring: valid/ready plus command fields.
// Depends on mhr_pkg.
interface mhr_in_if;
    import mhr_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         command;
    logic [TIME_W-1:0]        sample_time;
    logic                     sample_time_valid;
    logic [TIME_W-1:0]        now_time;
    logic                     cpu_ready;
    logic signed [RAW_W-1:0]  cpu_in;
    logic signed [RAW_W-1:0]  memory_in;
    logic signed [RAW_W-1:0]  disk_in;
    logic [LOAD_W-1:0]        load_avg;
    logic [CORE_W-1:0]        core_count;
    logic [WIN_W-1:0]         window_secs;

    modport source (
        output valid, command, sample_time, sample_time_valid, now_time, cpu_ready,
               cpu_in, memory_in, disk_in, load_avg, core_count, window_secs,
        input  ready
    );

    modport sink (
        input  valid, command, sample_time, sample_time_valid, now_time, cpu_ready,
               cpu_in, memory_in, disk_in, load_avg, core_count, window_secs,
        output ready
    );
endinterface

[hw/rtl/mhr_out_if.sv]
// Output channel of the metric history ring: valid/ready plus one stored point.
// Depends on mhr_pkg.
interface mhr_out_if;
    import mhr_pkg::*;

    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] point_time;
    logic              point_cpu_valid;
    logic [PCT_W-1:0]  point_cpu;
    logic [PCT_W-1:0]  point_memory;
    logic [PCT_W-1:0]  point_load;
    logic [PCT_W-1:0]  point_disk;
    logic              last;

    modport source (
        output valid, point_time, point_cpu_valid, point_cpu, point_memory,
               point_load, point_disk, last,
        input  ready
    );

    modport sink (
        input  valid, point_time, point_cpu_valid, point_cpu, point_memory,
               point_load, point_disk, last,
        output ready
    );
endinterface

[hw/rtl/metric_history_ring.sv]
// Metric history ring: keeps the last 32 telemetry points (oldest overwritten
// once full). One transaction is handled at a time. An append captures the item,
// runs the bit-serial load divider (23 quotient bits), then writes the point;
// a clear, an unused command or a query of an empty ring ends on acceptance;
// any other query reads the newest entry to set the cutoff, then walks the
// stored entries, each a registered read of the single point RAM followed by a
// cutoff compare; a hit waits while the result side stalls. The output register
// lets the next transaction be taken while the last result waits to be collected.
// Depends on mhr_pkg, mhr_in_if, mhr_out_if, mhr_ctrl and mhr_dp.
module metric_history_ring (
    input  logic   i_clk,
    input  logic   i_rst_n,
    mhr_in_if.sink    i_in,
    mhr_out_if.source o_out
);
    import mhr_pkg::*;

    t_ctl_cmd ctl_cmd;
    t_ctl_sts ctl_sts;
    t_in_item item;
    t_point   point;
    logic     out_valid;
    logic     out_last;
    logic     in_ready;

    assign item.command           = i_in.command;
    assign item.sample_time       = i_in.sample_time;
    assign item.sample_time_valid = i_in.sample_time_valid;
    assign item.now_time          = i_in.now_time;
    assign item.cpu_ready         = i_in.cpu_ready;
    assign item.cpu_in            = i_in.cpu_in;
    assign item.memory_in         = i_in.memory_in;
    assign item.disk_in           = i_in.disk_in;
    assign item.load_avg          = i_in.load_avg;
    assign item.core_count        = i_in.core_count;
    assign item.window_secs       = i_in.window_secs;

    mhr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (ctl_sts),
        .o_cmd      (ctl_cmd)
    );

    mhr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (ctl_cmd),
        .o_sts       (ctl_sts),
        .i_item      (item),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .o_point     (point),
        .o_last      (out_last)
    );

    assign i_in.ready            = in_ready;
    assign o_out.valid           = out_valid;
    assign o_out.point_time      = point.stamp;
    assign o_out.point_cpu_valid = point.cpu_valid;
    assign o_out.point_cpu       = point.cpu;
    assign o_out.point_memory    = point.memory;
    assign o_out.point_load      = point.load;
    assign o_out.point_disk      = point.disk;
    assign o_out.last            = out_last;
endmodule

[hw/rtl/mhr_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module mhr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[hw/rtl/mhr_dp.sv]
// Datapath of the metric history ring: ring pointers, point RAM, load divider,
// query cutoff and output register. Depends on mhr_pkg, mhr_ram and the macros header.
`include "metric_history_ring_macros.svh"

module mhr_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mhr_pkg::t_ctl_cmd i_cmd,
    output mhr_pkg::t_ctl_sts o_sts,
    input  mhr_pkg::t_in_item i_item,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output mhr_pkg::t_point   o_point,
    output logic              o_last
);
    import mhr_pkg::*;

    logic [IDX_W-1:0]     r_oldest;
    logic [CNT_W-1:0]     r_count;

    logic [TIME_W-1:0]    r_stamp;
    logic                 r_cpu_valid;
    logic [PCT_W-1:0]     r_cpu;
    logic [PCT_W-1:0]     r_mem;
    logic [PCT_W-1:0]     r_disk;
    logic [SPAN_W-1:0]    r_span;

    logic [CORE_W-1:0]    r_divisor;
    logic [DIV_W-1:0]     r_quo;
    logic [CORE_W-1:0]    r_rem;
    logic [DIV_CNT_W-1:0] r_div_cnt;

    logic [TIME_W-1:0]    r_cutoff;
    logic [IDX_W-1:0]     r_walk_slot;
    logic [CNT_W-1:0]     r_walk_k;

    logic                 r_out_valid;
    t_point               r_out_point;
    logic                 r_out_last;

    logic [CORE_W:0]      rem_sh;
    logic                 rem_ge;
    logic [CORE_W-1:0]    n_rem;
    logic [DIV_W-1:0]     n_quo;
    logic [PCT_W-1:0]     load_pct;
    logic                 full;
    logic [IDX_W-1:0]     slot_app;
    logic [IDX_W-1:0]     slot_newest;
    logic [IDX_W-1:0]     oldest_inc;
    logic [IDX_W-1:0]     walk_inc;
    logic [WIN_W-1:0]     win_eff;
    logic [TIME_W-1:0]    span_t;
    logic [TIME_W-1:0]    n_cutoff;
    t_point               wdata;
    t_point               rdata;
    logic [$bits(t_point)-1:0] rdata_raw;
    logic                 out_free;

    // restoring divide, one quotient bit per cycle
    assign rem_sh   = {r_rem, r_quo[DIV_W-1]};
    assign rem_ge   = rem_sh >= {1'b0, r_divisor};
    assign n_rem    = rem_ge ? CORE_W'(rem_sh - {1'b0, r_divisor}) : rem_sh[CORE_W-1:0];
    assign n_quo    = {r_quo[DIV_W-2:0], rem_ge};
    assign load_pct = (r_quo > DIV_W'(PCT_FULL)) ? PCT_FULL : r_quo[PCT_W-1:0];

    assign full        = r_count == CNT_W'(CAPACITY);
    assign slot_app    = idx_wrap({1'b0, r_oldest} + {1'b0, r_count[IDX_W-1:0]});
    assign slot_newest = idx_wrap({1'b0, r_oldest} + {1'b0, IDX_W'(r_count - 1'b1)});
    assign oldest_inc  = idx_wrap({1'b0, r_oldest} + (IDX_W+1)'(1));
    assign walk_inc    = idx_wrap({1'b0, r_walk_slot} + (IDX_W+1)'(1));

    assign win_eff  = (i_item.window_secs == '0) ? WIN_W'(1) : i_item.window_secs;
    assign span_t   = TIME_W'(r_span);
    assign n_cutoff = (rdata.stamp > span_t) ? rdata.stamp - span_t : '0;

    assign wdata.stamp     = r_stamp;
    assign wdata.cpu_valid = r_cpu_valid;
    assign wdata.cpu       = r_cpu;
    assign wdata.memory    = r_mem;
    assign wdata.load      = load_pct;
    assign wdata.disk      = r_disk;

    mhr_ram #(
        .WIDTH ($bits(t_point)),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.write),
        .i_waddr (full ? r_oldest : slot_app),
        .i_wdata (wdata),
        .i_re    (i_cmd.rd_newest | i_cmd.rd_walk),
        .i_raddr (i_cmd.rd_newest ? slot_newest : r_walk_slot),
        .o_rdata (rdata_raw)
    );

    assign rdata    = t_point'(rdata_raw);
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_oldest <= '0;
                r_count  <= '0;
            end else if (i_cmd.write) begin
                if (full) begin
                    r_oldest <= oldest_inc;
                end else begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_stamp     <= i_item.sample_time_valid ? i_item.sample_time : i_item.now_time;
            r_cpu_valid <= i_item.cpu_ready;
            r_cpu       <= clamp_pct(i_item.cpu_in);
            r_mem       <= clamp_pct(i_item.memory_in);
            r_disk      <= clamp_pct(i_item.disk_in);
            r_span      <= SPAN_W'(win_eff) * SPAN_W'(MS_PER_S);
            r_divisor   <= (i_item.core_count == '0) ? CORE_W'(1) : i_item.core_count;
            r_quo       <= DIV_W'(i_item.load_avg) * DIV_W'(LOAD_SCALE);
            r_rem       <= '0;
            r_div_cnt   <= '0;
        end else if (i_cmd.div_step) begin
            r_quo     <= n_quo;
            r_rem     <= n_rem;
            r_div_cnt <= r_div_cnt + 1'b1;
        end
        if (i_cmd.set_cutoff) begin
            r_cutoff <= n_cutoff;
        end
        if (i_cmd.rd_newest) begin
            r_walk_slot <= r_oldest;
            r_walk_k    <= '0;
        end else if (i_cmd.walk_next) begin
            r_walk_slot <= walk_inc;
            r_walk_k    <= r_walk_k + 1'b1;
        end
        if (i_cmd.emit) begin
            r_out_point <= rdata;
            r_out_last  <= o_sts.walk_end;
        end
    end

    assign o_sts.in_cmd   = i_item.command;
    assign o_sts.empty    = r_count == '0;
    assign o_sts.div_done = r_div_cnt == DIV_CNT_W'(DIV_W - 1);
    assign o_sts.hit      = rdata.stamp >= r_cutoff;
    // newest point always passes the cutoff, so the final entry ends the query
    assign o_sts.walk_end = r_walk_k == CNT_W'(r_count - 1'b1);
    assign o_sts.out_free = out_free;

    assign o_out_valid = r_out_valid;
    assign o_point     = r_out_point;
    assign o_last      = r_out_last;

    `MHR_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(CAPACITY), "entry count above capacity")
    `MHR_ASSERT_NEXT(a_clear_empties, i_clk, i_rst_n, i_cmd.clear, r_count == '0 && r_oldest == '0, "clear left ring non-empty")
    `MHR_ASSERT_NEXT(a_emit_shows, i_clk, i_rst_n, i_cmd.emit, r_out_valid, "emitted point not presented")
endmodule

[hw/rtl/mhr_ctrl.sv]
// Controller of the metric history ring: sequences append, clear and query.
// Depends on mhr_pkg and the macros header.
`include "metric_history_ring_macros.svh"

module mhr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  mhr_pkg::t_ctl_sts i_sts,
    output mhr_pkg::t_ctl_cmd o_cmd
);
    import mhr_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_DIV      = 7'b0000010,
        S_WRITE    = 7'b0000100,
        S_NEWEST   = 7'b0001000,
        S_CUTOFF   = 7'b0010000,
        S_WALK_RD  = 7'b0100000,
        S_WALK_CHK = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    case (i_sts.in_cmd)
                        CMD_APPEND: begin
                            n_state = S_DIV;
                        end
                        CMD_CLEAR: begin
                            o_cmd.clear = 1'b1;
                        end
                        CMD_QUERY: begin
                            if (!i_sts.empty) begin
                                n_state = S_NEWEST;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.write = 1'b1;
                n_state     = S_IDLE;
            end
            S_NEWEST: begin
                o_cmd.rd_newest = 1'b1;
                n_state         = S_CUTOFF;
            end
            S_CUTOFF: begin
                o_cmd.set_cutoff = 1'b1;
                n_state          = S_WALK_RD;
            end
            S_WALK_RD: begin
                o_cmd.rd_walk = 1'b1;
                n_state       = S_WALK_CHK;
            end
            S_WALK_CHK: begin
                if (!i_sts.hit || i_sts.out_free) begin
                    o_cmd.emit = i_sts.hit;
                    if (i_sts.walk_end) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.walk_next = 1'b1;
                        n_state         = S_WALK_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `MHR_ASSERT_NEXT(a_append_divides, i_clk, i_rst_n, r_state == S_IDLE && i_in_valid && i_sts.in_cmd == CMD_APPEND, r_state == S_DIV, "append did not start divide")
    `MHR_ASSERT_IMPL(a_write_after_div, i_clk, i_rst_n, r_state == S_WRITE, $past(r_state) == S_DIV, "write without divide")
    `MHR_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, r_state == S_WALK_CHK && i_sts.hit && !i_sts.out_free, r_state == S_WALK_CHK, "walk left a stalled hit")
endmodule
